// ===== src/wheel_speed_and_countdowns_core_macros.svh =====
// ----------------------------------------------------------------------------
// wheel speed and countdowns assertion macros
// shared concurrent assertion helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_AND_COUNTDOWNS_CORE_MACROS_SVH
`define WHEEL_SPEED_AND_COUNTDOWNS_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define WSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define WSC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition");
`else
`define WSC_ASSERT(lbl, prop)
`define WSC_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== src/wsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_pkg
// shared types and constants of the wheel speed and countdowns core
// ----------------------------------------------------------------------------
package wsc_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 184;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;

  // divider sizes: speed dividend is circ*9 << 17, divisor period*100
  localparam int unsigned DvdW = 37;
  localparam int unsigned DvsW = 24;
  localparam int unsigned DivCntW = 6;

  localparam logic [CfgIdxW-1:0] CfgCirc    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSvcKm   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTripKm  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTripSec = 2'd3;

  localparam logic [15:0] CircReset = 16'd2100;
  localparam logic [20:0] MmPerKm   = 21'd1000000;
  localparam logic [17:0] TicksPerSec = 18'd32768;
  localparam logic [17:0] TickAccMax  = 18'd131071;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic div_accel;   // 0: speed division, 1: acceleration division
    logic lat_speed;
    logic lat_accel;
    logic commit;
  } wsc_cmd_t;

  typedef struct packed {
    logic moving;
    logic div_done;
  } wsc_sts_t;

endpackage

// ===== src/wsc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wsc_div
  import wsc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quot_o
);

  logic [DvdW-1:0]    dvd_q, dvd_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DvsW-1:0]    dvs_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               done_q;
  logic [DvsW:0]      shifted;
  logic [DvsW+1:0]    trial;

  always_comb begin
    shifted = {rem_q, dvd_q[DvdW-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!trial[DvsW+1]) begin
        rem_d = trial[DvsW-1:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DvsW-1:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DivCntW'(DvdW);
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= (cnt_q == DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ===== src/wsc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_datapath
// input and config registers, shared divider, ride state and countdowns
// ----------------------------------------------------------------------------
module wsc_datapath
  import wsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wsc_cmd_t            cmd_i,
  output wsc_sts_t            sts_o,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic [OutDataW-1:0] out_data_o
);

  logic [15:0] period_q;
  logic [31:0] clk_sec_q;
  logic [15:0] circ_q;

  logic [15:0] speed_q;
  logic [31:0] accel_q;
  logic        neg_q;

  logic [15:0] prev_speed_q, peak_speed_q;
  logic [31:0] peak_accel_q, ride_start_q;
  logic [20:0] svc_acc_q, trip_acc_q;
  logic [17:0] tick_acc_q;
  logic [16:0] svc_cnt_q;
  logic [15:0] trip_cnt_q, sec_cnt_q;

  logic [OutDataW-1:0] out_q;

  // divider operands
  logic [DvdW-1:0] div_dvd;
  logic [DvsW-1:0] div_dvs;
  logic            div_done;
  logic [DvdW-1:0] div_quot;
  logic [19:0]     circ_x9;
  logic [15:0]     mag;
  logic            neg;

  always_comb begin
    circ_x9 = {4'b0, circ_q} + {1'b0, circ_q, 3'b000};
    neg     = speed_q < prev_speed_q;
    mag     = neg ? (prev_speed_q - speed_q) : (speed_q - prev_speed_q);
    if (cmd_i.div_accel) begin
      div_dvd = {6'b0, mag, 15'b0};
      div_dvs = {8'b0, period_q};
    end else begin
      div_dvd = {circ_x9, 17'b0};
      // period*100 = period*64 + period*32 + period*4
      div_dvs = {2'b0, period_q, 6'b0} + {3'b0, period_q, 5'b0} + {6'b0, period_q, 2'b0};
    end
  end

  wsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign sts_o.moving   = (period_q != '0);
  assign sts_o.div_done = div_done;

  // commit values
  logic        moving;
  logic [15:0] speed_w;
  logic [31:0] accel_w;
  logic [15:0] peak_speed_d, prev_speed_d;
  logic [31:0] peak_accel_d, ride_start_d;
  logic [20:0] svc_acc_d, trip_acc_d, svc_sum, trip_sum;
  logic [16:0] svc_cnt_d;
  logic [15:0] trip_cnt_d, sec_cnt_d;
  logic [17:0] tick_acc_d, tick_sum;
  logic        svc_alert, trip_alert, sec_alert;

  always_comb begin
    moving  = (period_q != '0);
    speed_w = moving ? speed_q : '0;
    accel_w = moving ? accel_q : '0;

    peak_speed_d = (moving && speed_q > peak_speed_q) ? speed_q : peak_speed_q;
    prev_speed_d = moving ? speed_q : prev_speed_q;
    if (!moving) begin
      peak_accel_d = '0;
      ride_start_d = '0;
    end else begin
      peak_accel_d = ($signed(accel_q) > $signed(peak_accel_q)) ? accel_q : peak_accel_q;
      ride_start_d = (ride_start_q == '0) ? clk_sec_q : ride_start_q;
    end

    // service km countdown
    svc_sum   = svc_acc_q + {5'b0, circ_q};
    svc_acc_d = svc_acc_q;
    svc_cnt_d = svc_cnt_q;
    svc_alert = 1'b0;
    if (svc_cnt_q != '0) begin
      svc_acc_d = svc_sum;
      if (svc_sum >= MmPerKm) begin
        svc_acc_d = svc_sum - MmPerKm;
        if (svc_cnt_q == 17'd1) begin
          svc_alert = 1'b1;
          svc_acc_d = '0;
        end
        svc_cnt_d = svc_cnt_q - 1'b1;
      end
    end

    // trip km countdown
    trip_sum   = trip_acc_q + {5'b0, circ_q};
    trip_acc_d = trip_acc_q;
    trip_cnt_d = trip_cnt_q;
    trip_alert = 1'b0;
    if (trip_cnt_q != '0) begin
      trip_acc_d = trip_sum;
      if (trip_sum >= MmPerKm) begin
        trip_acc_d = trip_sum - MmPerKm;
        if (trip_cnt_q == 16'd1) begin
          trip_alert = 1'b1;
          trip_acc_d = '0;
        end
        trip_cnt_d = trip_cnt_q - 1'b1;
      end
    end

    // trip seconds countdown, accumulator saturates at 17 bits
    tick_sum   = tick_acc_q + {2'b0, period_q};
    tick_acc_d = tick_acc_q;
    sec_cnt_d  = sec_cnt_q;
    sec_alert  = 1'b0;
    if (sec_cnt_q != '0) begin
      tick_acc_d = (tick_sum > TickAccMax) ? TickAccMax : tick_sum;
      if (tick_acc_d > TicksPerSec) begin
        tick_acc_d = tick_acc_d - TicksPerSec;
        if (sec_cnt_q == 16'd1) begin
          sec_alert  = 1'b1;
          tick_acc_d = '0;
        end
        sec_cnt_d = sec_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q       <= CircReset;
      prev_speed_q <= '0;
      peak_speed_q <= '0;
      peak_accel_q <= '0;
      ride_start_q <= '0;
      svc_acc_q    <= '0;
      trip_acc_q   <= '0;
      tick_acc_q   <= '0;
      svc_cnt_q    <= '0;
      trip_cnt_q   <= '0;
      sec_cnt_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgCirc: circ_q <= cfg_wdata_i[15:0];
        CfgSvcKm: begin
          svc_cnt_q <= cfg_wdata_i;
          svc_acc_q <= '0;
        end
        CfgTripKm: begin
          trip_cnt_q <= cfg_wdata_i[15:0];
          trip_acc_q <= '0;
        end
        CfgTripSec: begin
          sec_cnt_q  <= cfg_wdata_i[15:0];
          tick_acc_q <= '0;
        end
        default: ;
      endcase
    end else if (cmd_i.commit) begin
      prev_speed_q <= prev_speed_d;
      peak_speed_q <= peak_speed_d;
      peak_accel_q <= peak_accel_d;
      ride_start_q <= ride_start_d;
      svc_acc_q    <= svc_acc_d;
      trip_acc_q   <= trip_acc_d;
      tick_acc_q   <= tick_acc_d;
      svc_cnt_q    <= svc_cnt_d;
      trip_cnt_q   <= trip_cnt_d;
      sec_cnt_q    <= sec_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      period_q  <= in_data_i[15:0];
      clk_sec_q <= in_data_i[47:16];
    end
    if (cmd_i.div_start && cmd_i.div_accel) begin
      neg_q <= neg;
    end
    if (cmd_i.lat_speed) begin
      speed_q <= (div_quot[DvdW-1:16] != '0) ? 16'hFFFF : div_quot[15:0];
    end
    if (cmd_i.lat_accel) begin
      accel_q <= neg_q ? (32'd0 - div_quot[31:0]) : div_quot[31:0];
    end
    if (cmd_i.commit) begin
      out_q <= {4'b0, sec_alert, trip_alert, svc_alert, sec_cnt_d, trip_cnt_d,
                svc_cnt_d, ride_start_d, peak_accel_d, accel_w, peak_speed_d,
                speed_w};
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== src/wsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_ctrl
// sequencer for one revolution: load, two divisions when moving, commit to output
// ----------------------------------------------------------------------------
`include "wheel_speed_and_countdowns_core_macros.svh"

module wsc_ctrl
  import wsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  output logic     m_tvalid_o,
  input  logic     m_tready_i,
  input  wsc_sts_t sts_i,
  output wsc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StSpdGo,
    StSpdWait,
    StAccGo,
    StAccWait,
    StCommit
  } state_e;

  state_e state_q;
  logic   m_tvalid_q;
  logic   slot_free;

  assign slot_free  = !m_tvalid_q || m_tready_i;
  assign s_tready_o = (state_q == StIdle);
  assign m_tvalid_o = m_tvalid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_in   = (state_q == StIdle) && s_tvalid_i;
    cmd_o.div_start = ((state_q == StSpdGo) && sts_i.moving) || (state_q == StAccGo);
    cmd_o.div_accel = (state_q == StAccGo);
    cmd_o.lat_speed = (state_q == StSpdWait) && sts_i.div_done;
    cmd_o.lat_accel = (state_q == StAccWait) && sts_i.div_done;
    cmd_o.commit    = (state_q == StCommit) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      m_tvalid_q <= 1'b0;
    end else begin
      if ((state_q == StCommit) && slot_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_tvalid_i) begin
            state_q <= StSpdGo;
          end
        end
        StSpdGo: begin
          state_q <= sts_i.moving ? StSpdWait : StCommit;
        end
        StSpdWait: begin
          if (sts_i.div_done) begin
            state_q <= StAccGo;
          end
        end
        StAccGo: begin
          state_q <= StAccWait;
        end
        StAccWait: begin
          if (sts_i.div_done) begin
            state_q <= StCommit;
          end
        end
        StCommit: begin
          if (slot_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `WSC_ASSERT(a_commit_slot, cmd_o.commit |-> slot_free)
  `WSC_ASSERT(a_commit_valid, cmd_o.commit |=> m_tvalid_o)
  `WSC_ASSERT_NEVER(a_single_cmd, cmd_o.load_in && (cmd_o.div_start || cmd_o.commit))
  `WSC_ASSERT(a_done_waits, sts_i.div_done |-> (state_q == StSpdWait || state_q == StAccWait))

endmodule

// ===== src/wheel_speed_and_countdowns_core.sv =====
`timescale 1ns / 1ps
// a moving revolution runs the serial divider twice, for speed then
// acceleration; a stopped revolution (period 0) skips both divisions
// one revolution in flight: no new request is taken until the last one is
// committed, which waits for a free output slot; the next request is taken
// while a result waits
// reset: asynchronous active low, circumference 2100 mm, ride state and
// countdowns cleared, no clearing pass
// ----------------------------------------------------------------------------
// wheel_speed_and_countdowns_core
// wheel speed, acceleration, peaks, ride start and distance/time countdowns
// ----------------------------------------------------------------------------
module wheel_speed_and_countdowns_core
  import wsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // period_ticks[15:0], clock_seconds[47:16]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // speed[15:0], peak_speed_out[31:16], acceleration[63:32],
  // peak_accel_out[95:64], start_time[127:96], service_km_left[144:128],
  // trip_km_left[160:145], trip_sec_left[176:161], service_alert[177],
  // distance_alert[178], time_alert[179], zero fill[183:180]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  wsc_cmd_t cmd;
  wsc_sts_t sts;

  wsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wsc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (m_axis_tdata)
  );

endmodule
